@@ rtl/hbnc_pkg.sv @@
// Package for the hashed bit-sliced name CAM: sizes, word types and codes.
// Used by the top, controller and datapath modules; depends on nothing.
package hbnc_pkg;

   localparam int NumBuckets     = 16;
   localparam int SlotsPerBucket = 64;
   localparam int MaxNameLen     = 8;
   localparam int NamePositions  = MaxNameLen + 1;
   localparam int BucketBits     = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
   localparam int PosBits        = $clog2(NamePositions + 1);
   localparam int LenBits        = $clog2(MaxNameLen + 2);
   localparam int BufBits        = (MaxNameLen > 1) ? $clog2(MaxNameLen) : 1;
   localparam int BitmapDepth    = NumBuckets * NamePositions * 256;
   localparam int BitmapAddrBits = $clog2(BitmapDepth);
   localparam int HandleDepth    = NumBuckets * SlotsPerBucket;
   localparam int HandleAddrBits = $clog2(HandleDepth);
   localparam int ProbeBits      = $clog2(NumBuckets + 1);

   localparam logic [7:0] HashSeed = 8'd129;
   localparam logic [7:0] EndMark  = 8'h20;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusMiss    = 2'd1;
   localparam logic [1:0] StatusFull    = 2'd2;
   localparam logic [1:0] StatusTooLong = 2'd3;

   localparam logic OpInsert = 1'b0;
   localparam logic OpLookup = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [7:0]  name_byte;
      logic        last_byte;
      logic        empty_name;
      logic [15:0] entry_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  bucket_index;
      logic [5:0]  slot_index;
      logic [15:0] found_handle;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic take_byte;    // buffer a name byte and fold it into the hash
      logic start_op;     // latch op, handle, length, home bucket; reset name
      logic clear_step;   // write zero into the next bitmap word
      logic probe_init;   // reset match word, position counter for a bucket
      logic pos_read;     // issue read of bitmap word at current position
      logic pos_use;      // consume read data (AND or OR-write)
      logic next_bucket;  // advance to next bucket
      logic commit_ins;   // store handle and bump fill
      logic hrd;          // issue handle read for winning slot
      logic load_rsp;     // load result register
      logic [1:0] rsp_status;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic clear_done;
      logic too_long;
      logic op_lookup;
      logic bucket_full;
      logic pos_last;     // current position is the end mark position
      logic match_any;
      logic probes_done;
   } sts_type;

   // Highest set bit of a 32-bit word, zero when none.
   function automatic logic [4:0] highest32(input logic [31:0] w);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (w[i]) r = 5'(i);
      end
      return r;
   endfunction

endpackage

@@ rtl/hashed_bitsliced_name_cam_top.sv @@
// Top level of the hashed bit-sliced name CAM; joins controller and datapath.
// Depends on hbnc_pkg, hbnc_ctrl, hbnc_dp.
// A name is taken one byte per accepted request. On the last byte the block
// walks the name positions plus the end mark (bitmap memory read, then AND
// or write-back) per probed bucket, after setup, then decides and replies; a
// lookup hit first reads the handle memory. A lookup probes a further bucket
// only when the one it missed in is full, and an insert skips each full
// bucket. A name that is too long is answered without a probe. A stalled
// result holds the block in its reply state. After reset a clearing pass
// writes the 36864-word bitmap memory, one word a cycle, and no byte is
// accepted until it ends.
module hashed_bitsliced_name_cam_top import hbnc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   cmd_type cmd;
   sts_type sts;
   logic    rsp_busy;

   hbnc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_last(req_data.last_byte), .req_empty(req_data.empty_name),
      .req_stall(req_stall), .rsp_busy(rsp_busy), .sts(sts), .cmd(cmd));

   hbnc_dp u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .sts(sts),
      .rsp_busy(rsp_busy), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp(rsp_data));
endmodule

@@ rtl/hbnc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hbnc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/hbnc_ctrl.sv @@
// Controller state machine for the name CAM: sequences clear, probe and reply.
// Depends on hbnc_pkg.
module hbnc_ctrl import hbnc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   input  logic    req_empty,
   output logic    req_stall,
   input  logic    rsp_busy,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [3:0] StClear = 4'd0;
   localparam logic [3:0] StIdle  = 4'd1;
   localparam logic [3:0] StStart = 4'd2;
   localparam logic [3:0] StBkt   = 4'd3;
   localparam logic [3:0] StRead  = 4'd4;
   localparam logic [3:0] StUse   = 4'd5;
   localparam logic [3:0] StDecide= 4'd6;
   localparam logic [3:0] StHrd   = 4'd7;
   localparam logic [3:0] StHwait = 4'd8;
   localparam logic [3:0] StReply = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] stat_ff, stat_in;
   logic       accept;

   assign req_stall = (state_ff != StIdle);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      stat_in  = stat_ff;
      cmd      = '0;
      cmd.rsp_status = stat_ff;
      case (state_ff)
         StClear: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = StIdle;
         end
         StIdle: begin
            if (accept) begin
               cmd.take_byte = !req_empty;
               if (req_last || req_empty) begin
                  cmd.start_op = 1'b1;
                  state_in = StStart;
               end
            end
         end
         StStart: begin
            if (sts.too_long) begin
               stat_in = StatusTooLong;
               state_in = StReply;
            end else begin
               state_in = StBkt;
            end
         end
         StBkt: begin
            if (sts.probes_done) begin
               stat_in  = sts.op_lookup ? StatusMiss : StatusFull;
               state_in = StReply;
            end else if (!sts.op_lookup && sts.bucket_full) begin
               cmd.next_bucket = 1'b1;
            end else begin
               cmd.probe_init = 1'b1;
               state_in = StRead;
            end
         end
         StRead: begin
            cmd.pos_read = 1'b1;
            state_in = StUse;
         end
         StUse: begin
            cmd.pos_use = 1'b1;
            state_in = sts.pos_last ? StDecide : StRead;
         end
         StDecide: begin
            if (!sts.op_lookup) begin
               cmd.commit_ins = 1'b1;
               stat_in  = StatusOk;
               state_in = StReply;
            end else if (sts.match_any) begin
               state_in = StHrd;
            end else if (sts.bucket_full) begin
               cmd.next_bucket = 1'b1;
               state_in = StBkt;
            end else begin
               stat_in  = StatusMiss;
               state_in = StReply;
            end
         end
         StHrd: begin
            cmd.hrd = 1'b1;
            state_in = StHwait;
         end
         StHwait: begin
            stat_in  = StatusOk;
            state_in = StReply;
         end
         StReply: begin
            if (!rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StClear;
         stat_ff  <= StatusOk;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
      end
   end

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != StIdle) |-> req_stall)
      else $error("input taken while busy");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.pos_read, cmd.pos_use, cmd.hrd, cmd.load_rsp}) <= 1)
      else $error("conflicting commands");
   a_use_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.pos_read |=> cmd.pos_use)
      else $error("read not consumed");
endmodule

@@ rtl/hbnc_dp.sv @@
// Datapath of the name CAM: name buffer, hash, bitmap and handle memories,
// probe counters, match word and result register. Depends on hbnc_pkg, hbnc_ram.
module hbnc_dp import hbnc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_busy,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);
   logic [7:0]   buf_ff [MaxNameLen];
   logic [7:0]   hash_ff, hash_in;
   logic [LenBits-1:0] len_ff, len_in;
   logic [LenBits-1:0] oplen_ff;
   logic         op_ff;
   logic [15:0]  handle_ff;
   logic [BucketBits-1:0] bkt_ff;
   logic [ProbeBits-1:0]  probes_ff;
   logic [PosBits-1:0]    pos_ff;
   logic [63:0]  match_ff;
   logic [6:0]   fill_ff [NumBuckets];
   logic [BitmapAddrBits:0] clr_ff;
   logic [5:0]   slot_ff;
   logic [BitmapAddrBits-1:0] bm_addr_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff;

   logic [BitmapAddrBits-1:0] bm_waddr, bm_raddr;
   logic [63:0]  bm_wdata, bm_rdata;
   logic         bm_we;
   logic [7:0]   cur_byte;
   logic [15:0]  h_rdata;
   logic [HandleAddrBits-1:0] h_addr;
   logic [5:0]   win_slot;
   logic [BufBits-1:0] buf_idx;

   assign buf_idx  = pos_ff[BufBits-1:0];
   assign cur_byte = (pos_ff == PosBits'(oplen_ff)) ? EndMark : buf_ff[buf_idx];
   assign bm_raddr = BitmapAddrBits'(
      (32'(bkt_ff) * NamePositions + 32'(pos_ff)) * 256 + 32'(cur_byte));

   always_comb begin
      bm_we    = 1'b0;
      bm_waddr = bm_addr_ff;
      bm_wdata = bm_rdata | (64'd1 << slot_ff);
      if (cmd.clear_step) begin
         bm_we    = 1'b1;
         bm_waddr = clr_ff[BitmapAddrBits-1:0];
         bm_wdata = '0;
      end else if (cmd.pos_use && op_ff == OpInsert) begin
         bm_we = 1'b1;
      end
   end

   hbnc_ram #(.Width(64), .Depth(BitmapDepth)) u_bitmaps (
      .clock(clock), .wr_en(bm_we), .wr_addr(bm_waddr), .wr_data(bm_wdata),
      .rd_addr(bm_raddr), .rd_data(bm_rdata));

   assign win_slot = (match_ff[31:0] != 32'd0) ? {1'b0, highest32(match_ff[31:0])}
                                               : {1'b1, highest32(match_ff[63:32])};
   assign h_addr = cmd.commit_ins ? HandleAddrBits'({bkt_ff, slot_ff})
                                  : HandleAddrBits'({bkt_ff, win_slot});

   hbnc_ram #(.Width(16), .Depth(HandleDepth)) u_handles (
      .clock(clock), .wr_en(cmd.commit_ins), .wr_addr(h_addr), .wr_data(handle_ff),
      .rd_addr(h_addr), .rd_data(h_rdata));

   always_comb begin
      hash_in = hash_ff;
      len_in  = len_ff;
      if (cmd.take_byte) begin
         hash_in = hash_ff * req.name_byte;
         if (len_ff <= LenBits'(MaxNameLen)) len_in = len_ff + 1'b1;
      end
      if (cmd.start_op) begin
         hash_in = HashSeed;
         len_in  = '0;
      end
   end

   assign sts.clear_done  = (clr_ff == (BitmapAddrBits+1)'(BitmapDepth - 1));
   assign sts.too_long    = (oplen_ff > LenBits'(MaxNameLen));
   assign sts.op_lookup   = (op_ff == OpLookup);
   assign sts.bucket_full = (fill_ff[bkt_ff] == 7'd64);
   assign sts.pos_last    = (pos_ff == PosBits'(oplen_ff));
   assign sts.match_any   = (match_ff != 64'd0);
   assign sts.probes_done = (probes_ff == ProbeBits'(NumBuckets));

   assign rsp_busy  = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_byte && len_ff < LenBits'(MaxNameLen))
         buf_ff[len_ff[BufBits-1:0]] <= req.name_byte;
      if (cmd.start_op) begin
         op_ff     <= req.operation;
         handle_ff <= req.entry_handle;
         oplen_ff  <= req.empty_name ? '0 :
                      (len_ff <= LenBits'(MaxNameLen) ? len_ff + 1'b1 : len_ff);
         bkt_ff    <= req.empty_name ? BucketBits'(HashSeed % NumBuckets) :
                      BucketBits'(8'(hash_ff * req.name_byte) % NumBuckets);
         probes_ff <= '0;
      end
      if (cmd.probe_init) begin
         match_ff <= '1;
         pos_ff   <= '0;
         slot_ff  <= fill_ff[bkt_ff][5:0];
      end
      if (cmd.pos_read) bm_addr_ff <= bm_raddr;
      if (cmd.pos_use) begin
         match_ff <= match_ff & bm_rdata;
         pos_ff   <= pos_ff + 1'b1;
      end
      if (cmd.next_bucket) begin
         bkt_ff    <= (32'(bkt_ff) == NumBuckets - 1) ? '0 : bkt_ff + 1'b1;
         probes_ff <= probes_ff + 1'b1;
      end
      if (cmd.hrd) slot_ff <= win_slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= HashSeed;
         len_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NumBuckets; i++) fill_ff[i] <= '0;
      end else begin
         hash_ff <= hash_in;
         len_ff  <= len_in;
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.commit_ins) fill_ff[bkt_ff] <= fill_ff[bkt_ff] + 1'b1;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff.status <= cmd.rsp_status;
            if (cmd.rsp_status == StatusOk) begin
               rsp_ff.bucket_index <= 8'(bkt_ff);
               rsp_ff.slot_index   <= slot_ff;
               rsp_ff.found_handle <= (op_ff == OpLookup) ? h_rdata : handle_ff;
            end else begin
               rsp_ff.bucket_index <= '0;
               rsp_ff.slot_index   <= '0;
               rsp_ff.found_handle <= '0;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_ins |-> fill_ff[bkt_ff] < 7'd64)
      else $error("insert into full bucket");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !rsp_busy)
      else $error("result overwritten");
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.next_bucket |-> probes_ff < ProbeBits'(NumBuckets))
      else $error("probe count overrun");
endmodule
